### design/clbs_pkg.sv
// Shared types, constants and decode functions for the character LCD bus sequencer.
// No dependencies; the front, queue, back and top-level files import this package.
package clbs_pkg;

  // Connection modes (configuration register values)
  localparam logic [1:0] MODE_PAR8 = 2'd0;
  localparam logic [1:0] MODE_PAR4 = 2'd1;
  localparam logic [1:0] MODE_I2C4 = 2'd2;
  localparam logic [1:0] MODE_ALT8 = 2'd3;

  // Request opcodes
  localparam logic [1:0] OP_INSTR  = 2'd0;
  localparam logic [1:0] OP_DATA   = 2'd1;
  localparam logic [1:0] OP_CURSOR = 2'd2;
  localparam logic [1:0] OP_INIT   = 2'd3;

  // Bus byte bit positions
  localparam int BIT_RS = 0;
  localparam int BIT_RW = 1;
  localparam int BIT_EN = 2;
  localparam int BIT_BL = 3;

  localparam logic [2:0] MAX_ROW       = 3'd3;
  localparam logic [7:0] SET_DDRAM     = 8'h80;
  localparam logic [5:0] HOLD_POWER_UP = 6'd50;
  localparam logic [5:0] HOLD_PHASE    = 6'd1;
  localparam logic [5:0] HOLD_NONE     = 6'd0;

  // Init sequence steps
  localparam logic [3:0] STEP_FUNC_FIRST = 4'd4;
  localparam logic [3:0] STEP_FUNC_SECOND = 4'd5;
  localparam logic [3:0] STEP_LAST       = 4'd9;

  typedef enum logic {
    CMD_WRITE,
    CMD_PREAMBLE
  } cmd_kind_t;

  // One bus write handed from the front to the back
  typedef struct packed {
    cmd_kind_t  kind;
    logic       rs;
    logic [7:0] code;
    logic [2:0] extra;     // added to the last EN-low hold
    logic       set_spd;   // start phase is over after this write
    logic       last;      // final write of the item
  } cmd_t;

  // Mode three behaves as parallel 8-bit
  function automatic logic [1:0] eff_mode(input logic [1:0] mode);
    return (mode == MODE_ALT8) ? MODE_PAR8 : mode;
  endfunction

  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] base;
    unique case (row)
      2'd0:    base = 8'd0;
      2'd1:    base = 8'd64;
      2'd2:    base = 8'd20;
      default: base = 8'd84;
    endcase
    return base;
  endfunction

  // Command for one step of the power-on init sequence
  function automatic cmd_t init_cmd(input logic [3:0] step, input logic [1:0] mode);
    cmd_t c;
    c.kind    = CMD_WRITE;
    c.rs      = 1'b0;
    c.code    = 8'h30;
    c.extra   = 3'd1;
    c.set_spd = 1'b0;
    c.last    = (step == STEP_LAST);
    unique case (step)
      4'd0: c.kind = CMD_PREAMBLE;
      4'd1: c.extra = 3'd5;
      4'd2, 4'd3: c.code = 8'h30;
      4'd4: begin
        c.code    = (mode == MODE_PAR8) ? 8'h38 : 8'h20;
        c.set_spd = (mode != MODE_PAR8);
      end
      4'd5: c.code = 8'h28;
      4'd6: c.code = 8'h08;
      4'd7: c.code = 8'h01;
      4'd8: c.code = 8'h06;
      default: c.code = 8'h0C;
    endcase
    return c;
  endfunction

endpackage

### design/clbs_front.sv
// Front end: accepts request items and turns each into bus write commands.
// Depends on clbs_pkg.
module clbs_front
  import clbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] mode,
  input  logic       push,
  output logic       full,
  input  logic [1:0] opcode,
  input  logic [7:0] byte_value,
  input  logic [5:0] column,
  input  logic [2:0] row,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  typedef enum logic { F_IDLE, F_INIT } front_state_t;

  front_state_t state;
  logic [3:0]   step;
  logic         accept;
  logic [1:0]   emode;

  assign emode  = eff_mode(mode);
  assign full   = (state != F_IDLE) || q_full;
  assign accept = push && !full;

  always_comb begin
    q_cmd         = init_cmd(step, emode);
    q_push        = 1'b0;
    if (state == F_IDLE) begin
      q_cmd.kind    = CMD_WRITE;
      q_cmd.rs      = (opcode == OP_DATA);
      q_cmd.code    = byte_value;
      q_cmd.extra   = 3'd0;
      q_cmd.set_spd = 1'b0;
      q_cmd.last    = 1'b1;
      if (opcode == OP_CURSOR) begin
        q_cmd.code  = SET_DDRAM | (row_base(row[1:0]) + {2'b00, column});
        q_cmd.extra = 3'd1;
      end
      // drop cursor moves to rows that do not exist, and hand init to the sequencer
      q_push = accept && (opcode != OP_INIT) && !((opcode == OP_CURSOR) && (row > MAX_ROW));
    end else begin
      q_push = !q_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      step  <= 4'd0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept && (opcode == OP_INIT)) begin
            state <= F_INIT;
            step  <= 4'd0;
          end
        end
        F_INIT: begin
          if (q_push) begin
            if (step == STEP_LAST) begin
              state <= F_IDLE;
            end else if ((step == STEP_FUNC_FIRST) && (emode == MODE_PAR8)) begin
              step <= STEP_FUNC_SECOND + 4'd1;
            end else begin
              step <= step + 4'd1;
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

### design/clbs_cmd_queue.sv
// Two-entry command queue between the front and back ends.
// Depends on clbs_pkg for the command type.
module clbs_cmd_queue
  import clbs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= !wr_ptr;
      if (pop && !empty) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, (push && !full)} - {1'b0, (pop && !empty)};
    end
  end

endmodule

### design/clbs_back.sv
// Back end: executes write commands as strobes and emits one bus snapshot per cycle while pop keeps up.
// Depends on clbs_pkg; owns the pin latches and the start-phase flag.
module clbs_back
  import clbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] mode,
  input  logic       q_empty,
  input  cmd_t       q_head,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] bus_byte,
  output logic [3:0] low_data_pins,
  output logic [5:0] hold_ms,
  output logic       last
);

  typedef enum logic [1:0] { B_IDLE, B_PRE, B_STROBE } back_state_t;

  back_state_t state;
  cmd_t        cur;
  logic        nib_sel;
  logic [1:0]  phase;
  logic        two_nib;
  logic        spd;
  logic [7:0]  latch;
  logic [3:0]  low_latch;
  logic        out_valid;

  logic [1:0]  emode;
  logic        emit_ok;
  logic        load_out;
  logic [7:0]  latch_next;
  logic [3:0]  nib;
  logic        final_strobe;
  logic [5:0]  hold_next;

  assign emode    = eff_mode(mode);
  assign emit_ok  = !out_valid || pop;
  assign load_out = ((state == B_PRE) || (state == B_STROBE)) && emit_ok;
  assign empty    = !out_valid;
  assign q_pop    = (state == B_IDLE) && !q_empty;

  assign nib          = nib_sel ? cur.code[3:0] : cur.code[7:4];
  assign final_strobe = nib_sel || !two_nib;

  always_comb begin
    latch_next = latch;
    hold_next  = HOLD_NONE;
    unique case (phase)
      2'd0: latch_next = {nib, latch[3:0] & 4'b1011};
      2'd1: begin
        latch_next[BIT_EN] = 1'b1;
        hold_next          = HOLD_PHASE;
      end
      default: begin
        latch_next[BIT_EN] = 1'b0;
        hold_next = HOLD_PHASE + (final_strobe ? {3'd0, cur.extra} : 6'd0);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      spd       <= 1'b0;
      latch     <= 8'd0;
      low_latch <= 4'd0;
      phase     <= 2'd0;
      nib_sel   <= 1'b0;
      two_nib   <= 1'b0;
    end else begin
      out_valid <= load_out || (out_valid && !pop);
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            cur <= q_head;
            if (q_head.kind == CMD_PREAMBLE) begin
              if (emode == MODE_I2C4) latch[BIT_BL] <= 1'b1;
              spd   <= 1'b0;
              state <= B_PRE;
            end else begin
              latch[BIT_RS] <= q_head.rs;
              latch[BIT_RW] <= 1'b0;
              if (emode == MODE_PAR8) low_latch <= q_head.code[3:0];
              two_nib <= (emode != MODE_PAR8) && spd;
              nib_sel <= 1'b0;
              phase   <= 2'd0;
              state   <= B_STROBE;
            end
          end
        end
        B_PRE: begin
          if (emit_ok) begin
            bus_byte      <= (emode == MODE_I2C4) ? latch : (latch & ~(8'd1 << BIT_BL));
            low_data_pins <= (emode == MODE_PAR8) ? low_latch : 4'd0;
            hold_ms       <= HOLD_POWER_UP;
            last          <= cur.last;
            state         <= B_IDLE;
          end
        end
        B_STROBE: begin
          if (emit_ok) begin
            latch         <= latch_next;
            bus_byte      <= (emode == MODE_I2C4) ? latch_next
                                                  : (latch_next & ~(8'd1 << BIT_BL));
            low_data_pins <= (emode == MODE_PAR8) ? low_latch : 4'd0;
            hold_ms       <= hold_next;
            last          <= cur.last && final_strobe && (phase == 2'd2);
            if (phase == 2'd2) begin
              phase <= 2'd0;
              if (final_strobe) begin
                if (cur.set_spd) spd <= 1'b1;
                state <= B_IDLE;
              end else begin
                nib_sel <= 1'b1;
              end
            end else begin
              phase <= phase + 2'd1;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

### design/char_lcd_bus_sequencer.sv
// Top level of the character LCD bus sequencer: APB mode register, front end,
// command queue and back end. Depends on clbs_pkg, clbs_front, clbs_cmd_queue, clbs_back.
//
// Drives an HD44780-style character LCD bus. Each item is an instruction write,
// a data write, a cursor move (row 0-3, column) or a power-on init request; the
// block returns the bus states to drive, one snapshot per phase, each with a hold
// time in ms, and flags the final snapshot of the item with last. A byte is one
// strobe (three snapshots) in 8-bit mode, and two nibble strobes in 4-bit or
// expander mode once the start phase of init is over. A cursor move to a row
// above three gives no snapshot at all. The front takes an item and expands it
// into bus writes; the back fetches each write from the command queue and then
// emits one snapshot per cycle while pop keeps up. An item passes through the
// command queue and the back end's command register before its first snapshot
// is registered. A new item is taken while the back still drains the previous
// one, as long as the two-entry command queue has room; during init the front
// is busy until all of its writes are queued. Mode changes over the APB port
// are meant for idle periods only.
module char_lcd_bus_sequencer
  import clbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // request queue side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode,
  input  logic [7:0]  byte_value,
  input  logic [5:0]  column,
  input  logic [2:0]  row,
  // snapshot queue side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  bus_byte,
  output logic [3:0]  low_data_pins,
  output logic [5:0]  hold_ms,
  output logic        last,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0] connection_mode;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  cmd_t       q_in;
  cmd_t       q_head;

  // Single register at offset 0; the two low address bits are ignored
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {30'd0, connection_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      connection_mode <= MODE_PAR8;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      connection_mode <= pwdata[1:0];
    end
  end

  // Classify requests and expand init into its write list
  clbs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .mode       (connection_mode),
    .push       (push),
    .full       (full),
    .opcode     (opcode),
    .byte_value (byte_value),
    .column     (column),
    .row        (row),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_in)
  );

  // Decouple the front from the snapshot drain
  clbs_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // Run strobes and hold the result item until popped
  clbs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .mode          (connection_mode),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .bus_byte      (bus_byte),
    .low_data_pins (low_data_pins),
    .hold_ms       (hold_ms),
    .last          (last)
  );

endmodule

### design/clbs_checker.sv
// Port-level checker for the character LCD bus sequencer, bound to the top level.
// Depends only on the top level's ports.
module clbs_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [7:0] bus_byte,
  input logic [5:0] hold_ms,
  input logic       last
);

  // Hold a waiting item until it is taken
  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(bus_byte) && $stable(hold_ms) && $stable(last)))
    else $error("waiting item changed before pop");

  // EN-high phase always lasts one ms
  a_en_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && bus_byte[2]) |-> (hold_ms == 6'd1))
    else $error("EN-high snapshot with wrong hold");

  // Close every item with EN low
  a_last_en_low: assert property (@(posedge clk) disable iff (rst)
    (!empty && last) |-> !bus_byte[2])
    else $error("final snapshot with EN high");

  // Drive writes only, with holds of at most 50 ms
  a_rw_low: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (!bus_byte[1] && (hold_ms <= 6'd50)))
    else $error("read strobe or hold out of range");

endmodule

bind char_lcd_bus_sequencer clbs_checker u_clbs_checker (
  .clk      (clk),
  .rst      (rst),
  .empty    (empty),
  .pop      (pop),
  .bus_byte (bus_byte),
  .hold_ms  (hold_ms),
  .last     (last)
);
